// ----- rtl/rsi_pkg.sv -----
`timescale 1ns / 1ps
package rsi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int XW        = 32;
    localparam int EW        = XW + 1;
    localparam int RW_RAD    = XW - 1;
    localparam int AW        = 2 * XW;
    localparam int HW        = 2 * XW + 2;
    localparam int CW        = 2 * XW + 3;
    localparam int HL        = XW + 1;
    localparam int DW        = 2 * HW;
    localparam int PW        = DW - 2;
    localparam int RAD_W     = AW + 2 * RW_RAD + 2 * FRAC_BITS;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int NUM_W     = HW + FRAC_BITS;
    localparam int QW        = XW + 2;
    localparam int QS        = QW + 2;

    localparam logic [2:0] CFG_CENTER_X = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y = 3'd1;
    localparam logic [2:0] CFG_CENTER_Z = 3'd2;
    localparam logic [2:0] CFG_RADIUS   = 3'd3;
    localparam logic [2:0] CFG_T_LOWER  = 3'd4;
    localparam logic [2:0] CFG_T_UPPER  = 3'd5;

    localparam logic signed [XW-1:0] ONE_VAL  = XW'(1) << FRAC_BITS;
    localparam logic signed [XW-1:0] MISS_VAL = -ONE_VAL;
    localparam logic signed [XW-1:0] T_MAX    = {1'b0, {(XW-1){1'b1}}};
    localparam logic signed [XW-1:0] T_MIN    = {1'b1, {(XW-1){1'b0}}};

    typedef struct packed {
        logic signed [XW-1:0] origin_x;
        logic signed [XW-1:0] origin_y;
        logic signed [XW-1:0] origin_z;
        logic signed [XW-1:0] dir_x;
        logic signed [XW-1:0] dir_y;
        logic signed [XW-1:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic signed [XW-1:0] center_x;
        logic signed [XW-1:0] center_y;
        logic signed [XW-1:0] center_z;
        logic [XW-2:0]        sphere_radius;
        logic signed [XW-1:0] t_lower;
        logic signed [XW-1:0] t_upper;
    } cfg_t;

    typedef struct packed {
        logic                    miss;
        logic [AW-1:0]           a;
        logic signed [NUM_W:0]   hs;
    } side_t;

    typedef struct packed {
        logic                    miss;
        logic signed [NUM_W:0]   num;
        logic [AW-1:0]           a;
    } div_in_t;

    typedef struct packed {
        logic          miss;
        logic          neg;
        logic          ovf;
        logic [AW-1:0] a;
        logic [AW-1:0] rem;
        logic [QW-1:0] ql;
    } div_st_t;

endpackage

// ----- rtl/rsi_ray_if.sv -----
`timescale 1ns / 1ps
interface rsi_ray_if;
    logic                         valid;
    logic                         ready;
    logic signed [rsi_pkg::XW-1:0] origin_x;
    logic signed [rsi_pkg::XW-1:0] origin_y;
    logic signed [rsi_pkg::XW-1:0] origin_z;
    logic signed [rsi_pkg::XW-1:0] dir_x;
    logic signed [rsi_pkg::XW-1:0] dir_y;
    logic signed [rsi_pkg::XW-1:0] dir_z;

    modport source (output valid, output origin_x, output origin_y, output origin_z,
                    output dir_x, output dir_y, output dir_z, input ready);
    modport sink (input valid, input origin_x, input origin_y, input origin_z,
                  input dir_x, input dir_y, input dir_z, output ready);
endinterface

// ----- rtl/rsi_hit_if.sv -----
`timescale 1ns / 1ps
interface rsi_hit_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic signed [rsi_pkg::XW-1:0] t_near;
    logic signed [rsi_pkg::XW-1:0] t_far;

    modport source (output valid, output hit, output t_near, output t_far, input ready);
    modport sink (input valid, input hit, input t_near, input t_far, output ready);
endinterface

// ----- rtl/rsi_quad.sv -----
`timescale 1ns / 1ps
module rsi_quad (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_v,
    input  rsi_pkg::ray_t               ray,
    input  rsi_pkg::cfg_t               cfg,
    output logic                        out_v,
    output logic [rsi_pkg::RAD_W-1:0]   rad,
    output rsi_pkg::side_t              side
);

    localparam int XW = rsi_pkg::XW;
    localparam int EW = rsi_pkg::EW;
    localparam int AW = rsi_pkg::AW;
    localparam int HW = rsi_pkg::HW;
    localparam int CW = rsi_pkg::CW;
    localparam int HL = rsi_pkg::HL;
    localparam int DW = rsi_pkg::DW;
    localparam int PW = rsi_pkg::PW;
    localparam int F  = rsi_pkg::FRAC_BITS;
    localparam int NSW = rsi_pkg::NUM_W + 1;

    logic signed [XW-1:0] o_vec [3];
    logic signed [XW-1:0] d_vec [3];
    logic signed [XW-1:0] c_vec [3];

    // stage 1: offset from centre
    logic                 v1_reg;
    logic signed [XW-1:0] d1_reg [3];
    logic signed [EW-1:0] e1_reg [3];

    // stage 2: products
    logic                   v2_reg;
    logic signed [AW-1:0]   dd2_reg [3];
    logic signed [AW:0]     de2_reg [3];
    logic signed [AW+1:0]   ee2_reg [3];
    logic [2*XW-3:0]        rr2_reg;

    // stage 3: coefficients
    logic                 v3_reg;
    logic [AW-1:0]        a3_reg;
    logic signed [HW-1:0] h3_reg;
    logic signed [CW-1:0] c3_reg;

    // stage 4: partial products
    logic                    v4_reg;
    logic [2*HL-1:0]         p0_reg;
    logic [HW-2:0]           p1_reg;
    logic [2*(HW-1-HL)-1:0]  p2_reg;
    logic [XW+HL-1:0]        q00_reg, q01_reg, q10_reg, q11_reg;
    logic                    cneg4_reg;
    logic [AW-1:0]           a4_reg;
    logic signed [NSW-1:0]   hs4_reg;

    // stage 5: h squared and a times c assembled
    logic                  v5_reg;
    logic [PW-1:0]         hsq5_reg;
    logic [PW-1:0]         ac5_reg;
    logic                  cneg5_reg;
    logic [AW-1:0]         a5_reg;
    logic signed [NSW-1:0] hs5_reg;

    logic [HW-2:0] h_mag;
    logic [CW-2:0] c_mag;
    logic [DW-1:0] disc;
    logic [PW-1:0] hsq_next, ac_next;

    always_comb
    begin
        o_vec[0] = ray.origin_x;
        o_vec[1] = ray.origin_y;
        o_vec[2] = ray.origin_z;
        d_vec[0] = ray.dir_x;
        d_vec[1] = ray.dir_y;
        d_vec[2] = ray.dir_z;
        c_vec[0] = cfg.center_x;
        c_vec[1] = cfg.center_y;
        c_vec[2] = cfg.center_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            out_v  <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_v;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            out_v  <= v5_reg;
        end
    end

    always_comb
    begin
        h_mag = h3_reg[HW-1] ? (HW-1)'(-h3_reg) : h3_reg[HW-2:0];
        c_mag = c3_reg[CW-1] ? (CW-1)'(-c3_reg) : c3_reg[CW-2:0];
        hsq_next = (PW'(p2_reg) << (2 * HL)) + (PW'(p1_reg) << (HL + 1)) + PW'(p0_reg);
        ac_next  = (PW'(q11_reg) << (XW + HL)) + (PW'(q01_reg) << HL)
                 + (PW'(q10_reg) << XW) + PW'(q00_reg);
        disc = cneg5_reg ? ({2'b00, hsq5_reg} + {2'b00, ac5_reg})
                         : ({2'b00, hsq5_reg} - {2'b00, ac5_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i]  <= d_vec[i];
                e1_reg[i]  <= EW'(o_vec[i]) - EW'(c_vec[i]);
                dd2_reg[i] <= d1_reg[i] * d1_reg[i];
                de2_reg[i] <= (AW+1)'(d1_reg[i]) * (AW+1)'(e1_reg[i]);
                ee2_reg[i] <= (AW+2)'(e1_reg[i]) * (AW+2)'(e1_reg[i]);
            end
            rr2_reg <= (2*XW-2)'(cfg.sphere_radius) * (2*XW-2)'(cfg.sphere_radius);

            a3_reg <= AW'(dd2_reg[0]) + AW'(dd2_reg[1]) + AW'(dd2_reg[2]);
            h3_reg <= HW'(de2_reg[0]) + HW'(de2_reg[1]) + HW'(de2_reg[2]);
            c3_reg <= CW'(ee2_reg[0]) + CW'(ee2_reg[1]) + CW'(ee2_reg[2])
                    - CW'(rr2_reg);

            p0_reg    <= (2*HL)'(h_mag[HL-1:0]) * (2*HL)'(h_mag[HL-1:0]);
            p1_reg    <= (HW-1)'(h_mag[HW-2:HL]) * (HW-1)'(h_mag[HL-1:0]);
            p2_reg    <= (2*(HW-1-HL))'(h_mag[HW-2:HL]) * (2*(HW-1-HL))'(h_mag[HW-2:HL]);
            q00_reg   <= (XW+HL)'(a3_reg[XW-1:0]) * (XW+HL)'(c_mag[HL-1:0]);
            q01_reg   <= (XW+HL)'(a3_reg[XW-1:0]) * (XW+HL)'(c_mag[CW-2:HL]);
            q10_reg   <= (XW+HL)'(a3_reg[AW-1:XW]) * (XW+HL)'(c_mag[HL-1:0]);
            q11_reg   <= (XW+HL)'(a3_reg[AW-1:XW]) * (XW+HL)'(c_mag[CW-2:HL]);
            cneg4_reg <= c3_reg[CW-1];
            a4_reg    <= a3_reg;
            hs4_reg   <= -(NSW'(h3_reg) <<< F);

            hsq5_reg  <= hsq_next;
            ac5_reg   <= ac_next;
            cneg5_reg <= cneg4_reg;
            a5_reg    <= a4_reg;
            hs5_reg   <= hs4_reg;

            rad       <= {disc[rsi_pkg::RAD_W-2*F-1:0], {(2*F){1'b0}}};
            side.miss <= (a5_reg == '0) || disc[DW-1];
            side.a    <= a5_reg;
            side.hs   <= hs5_reg;
        end
    end

endmodule

// ----- rtl/rsi_sqrt.sv -----
`timescale 1ns / 1ps
module rsi_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_v,
    input  logic [rsi_pkg::RAD_W-1:0]   rad,
    input  rsi_pkg::side_t              in_side,
    output logic                        out_v,
    output logic [rsi_pkg::ROOT_W-1:0]  root,
    output rsi_pkg::side_t              out_side
);

    localparam int RAD_W  = rsi_pkg::RAD_W;
    localparam int ROOT_W = rsi_pkg::ROOT_W;
    localparam int RW     = ROOT_W + 2;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [RW-1:0]     rem;
        logic [ROOT_W-1:0] root;
        rsi_pkg::side_t    side;
    } sq_t;

    sq_t          st_reg [ROOT_W+1];
    logic [ROOT_W:0] sv_reg;

    always_comb
    begin
        st_reg[0].rad  = rad;
        st_reg[0].rem  = '0;
        st_reg[0].root = '0;
        st_reg[0].side = in_side;
        sv_reg[0]      = in_v;
    end

    // one result bit per stage
    for (genvar k = 1; k <= ROOT_W; k++)
    begin : g_step
        logic [RW+1:0] r2;
        logic [RW+1:0] trial;
        logic          ge;
        sq_t           st_next;

        always_comb
        begin
            r2      = {st_reg[k-1].rem, st_reg[k-1].rad[RAD_W-1 -: 2]};
            trial   = (RW+2)'({st_reg[k-1].root, 2'b01});
            ge      = r2 >= trial;
            st_next = st_reg[k-1];
            st_next.rad  = st_reg[k-1].rad << 2;
            st_next.rem  = ge ? RW'(r2 - trial) : RW'(r2);
            st_next.root = {st_reg[k-1].root[ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= st_next;
            end
        end
    end

    assign out_v    = sv_reg[ROOT_W];
    assign root     = st_reg[ROOT_W].root;
    assign out_side = st_reg[ROOT_W].side;

endmodule

// ----- rtl/rsi_div.sv -----
`timescale 1ns / 1ps
module rsi_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_v,
    input  rsi_pkg::div_in_t  din,
    output logic              out_v,
    output rsi_pkg::div_st_t  dout
);

    localparam int AW    = rsi_pkg::AW;
    localparam int QW    = rsi_pkg::QW;
    localparam int NUM_W = rsi_pkg::NUM_W;
    localparam int OVW   = AW + QW;

    logic                v0_reg;
    logic                miss0_reg;
    logic                neg0_reg;
    logic [NUM_W-1:0]    mag0_reg;
    logic [AW-1:0]       a0_reg;

    rsi_pkg::div_st_t    st_reg [QW+1];
    logic [QW:0]         sv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            sv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v0_reg    <= in_v;
            sv_reg[0] <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            miss0_reg <= din.miss;
            neg0_reg  <= din.num[NUM_W];
            mag0_reg  <= din.num[NUM_W] ? NUM_W'(-din.num) : din.num[NUM_W-1:0];
            a0_reg    <= din.a;

            st_reg[0].miss <= miss0_reg;
            st_reg[0].neg  <= neg0_reg;
            st_reg[0].ovf  <= OVW'(mag0_reg) >= {a0_reg, {QW{1'b0}}};
            st_reg[0].a    <= a0_reg;
            st_reg[0].rem  <= AW'(mag0_reg[NUM_W-1:QW]);
            st_reg[0].ql   <= mag0_reg[QW-1:0];
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QW; k++)
    begin : g_step
        logic [AW:0]      r2;
        logic             ge;
        rsi_pkg::div_st_t st_next;

        always_comb
        begin
            r2      = {st_reg[k-1].rem, st_reg[k-1].ql[QW-1]};
            ge      = r2 >= {1'b0, st_reg[k-1].a};
            st_next = st_reg[k-1];
            st_next.rem = ge ? AW'(r2 - {1'b0, st_reg[k-1].a}) : r2[AW-1:0];
            st_next.ql  = {st_reg[k-1].ql[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sv_reg[k] <= sv_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k] <= st_next;
            end
        end
    end

    assign out_v = sv_reg[QW];
    assign dout  = st_reg[QW];

endmodule

// ----- rtl/ray_sphere_intersect.sv -----
`timescale 1ns / 1ps
// ray / sphere intersection, fixed point
// ray (sink): one request per ray, origin and direction in signed Q16.16
// result (source): hit flag and the two roots t_near, t_far in signed Q16.16;
//   a miss gives hit low and both roots at -1.0
// cfg_we / cfg_idx / cfg_data: register writes (centre x/y/z, radius,
//   t_lower, t_upper), to be made by the user only while no ray is in
//   flight; the block itself does not enforce it
// throughput: one ray per clock unless the result stalls; rays overlap freely
// path from request to result: products and discriminant, 79 square root
//   stages (one root bit each), divider set-up, 34 divider stages (one
//   quotient bit each) and the output register
// reset: all stages empty, registers at centre 0, radius 1.0,
//   window [1.0, max]
// a stalled result holds the whole pipeline; the tail still closes up
//   when the last stage is empty, so ray stays ready until then
module ray_sphere_intersect (
    input  logic                      clk,
    input  logic                      rst_n,
    rsi_ray_if.sink                   ray,
    rsi_hit_if.source                 result,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_idx,
    input  logic [rsi_pkg::XW-1:0]    cfg_data
);

    localparam int XW = rsi_pkg::XW;
    localparam int QS = rsi_pkg::QS;
    localparam int NSW = rsi_pkg::NUM_W + 1;

    rsi_pkg::cfg_t    cfg_reg;
    rsi_pkg::ray_t    ray_in;

    logic                         en;
    logic                         q_v;
    logic [rsi_pkg::RAD_W-1:0]    q_rad;
    rsi_pkg::side_t               q_side;
    logic                         s_v;
    logic [rsi_pkg::ROOT_W-1:0]   s_root;
    rsi_pkg::side_t               s_side;
    rsi_pkg::div_in_t             dn_in, df_in;
    logic                         dn_v, df_v;
    rsi_pkg::div_st_t             dn_out, df_out;

    logic                 out_v_reg;
    logic                 hit_reg;
    logic signed [XW-1:0] tn_reg, tf_reg;

    logic                 ld;
    logic signed [QS-1:0] qn, qf;
    logic                 in_n, in_f, hit_next;

    function automatic logic signed [QS-1:0] fq(rsi_pkg::div_st_t d);
        logic signed [QS-1:0] m;
        m = QS'(d.ql);
        return d.neg ? (-m - QS'(|d.rem)) : m;
    endfunction

    function automatic logic in_win(rsi_pkg::div_st_t d, logic signed [QS-1:0] q,
                                    logic signed [XW-1:0] lo, logic signed [XW-1:0] hi);
        return !d.ovf && (q >= QS'(lo)) && (q <= QS'(hi));
    endfunction

    function automatic logic signed [XW-1:0] sat(rsi_pkg::div_st_t d,
                                                 logic signed [QS-1:0] q);
        logic signed [XW-1:0] r;
        if (d.ovf)
        begin
            r = d.neg ? rsi_pkg::T_MIN : rsi_pkg::T_MAX;
        end
        else if (q > QS'(rsi_pkg::T_MAX))
        begin
            r = rsi_pkg::T_MAX;
        end
        else if (q < QS'(rsi_pkg::T_MIN))
        begin
            r = rsi_pkg::T_MIN;
        end
        else
        begin
            r = q[XW-1:0];
        end
        return r;
    endfunction

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x      <= '0;
            cfg_reg.center_y      <= '0;
            cfg_reg.center_z      <= '0;
            cfg_reg.sphere_radius <= (XW-1)'(rsi_pkg::ONE_VAL);
            cfg_reg.t_lower       <= rsi_pkg::ONE_VAL;
            cfg_reg.t_upper       <= rsi_pkg::T_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                rsi_pkg::CFG_CENTER_X: cfg_reg.center_x      <= cfg_data;
                rsi_pkg::CFG_CENTER_Y: cfg_reg.center_y      <= cfg_data;
                rsi_pkg::CFG_CENTER_Z: cfg_reg.center_z      <= cfg_data;
                rsi_pkg::CFG_RADIUS:   cfg_reg.sphere_radius <= cfg_data[XW-2:0];
                rsi_pkg::CFG_T_LOWER:  cfg_reg.t_lower       <= cfg_data;
                rsi_pkg::CFG_T_UPPER:  cfg_reg.t_upper       <= cfg_data;
                default:               cfg_reg               <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        ray_in.origin_x = ray.origin_x;
        ray_in.origin_y = ray.origin_y;
        ray_in.origin_z = ray.origin_z;
        ray_in.dir_x    = ray.dir_x;
        ray_in.dir_y    = ray.dir_y;
        ray_in.dir_z    = ray.dir_z;
    end

    // pipeline holds only while an output result is blocked and dn_v is set
    assign ld        = !out_v_reg || result.ready;
    assign en        = ld || !dn_v;
    assign ray.ready = en;

    rsi_quad u_quad (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (ray.valid),
        .ray   (ray_in),
        .cfg   (cfg_reg),
        .out_v (q_v),
        .rad   (q_rad),
        .side  (q_side)
    );

    rsi_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (q_v),
        .rad      (q_rad),
        .in_side  (q_side),
        .out_v    (s_v),
        .root     (s_root),
        .out_side (s_side)
    );

    always_comb
    begin
        dn_in.miss = s_side.miss;
        dn_in.a    = s_side.a;
        dn_in.num  = s_side.hs - NSW'(s_root);
        df_in.miss = s_side.miss;
        df_in.a    = s_side.a;
        df_in.num  = s_side.hs + NSW'(s_root);
    end

    rsi_div u_div_near (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (s_v),
        .din   (dn_in),
        .out_v (dn_v),
        .dout  (dn_out)
    );

    rsi_div u_div_far (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .in_v  (s_v),
        .din   (df_in),
        .out_v (df_v),
        .dout  (df_out)
    );

    always_comb
    begin
        qn       = fq(dn_out);
        qf       = fq(df_out);
        in_n     = in_win(dn_out, qn, cfg_reg.t_lower, cfg_reg.t_upper);
        in_f     = in_win(df_out, qf, cfg_reg.t_lower, cfg_reg.t_upper);
        hit_next = !dn_out.miss && (in_n || in_f);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (ld)
        begin
            out_v_reg <= dn_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            hit_reg <= hit_next;
            tn_reg  <= hit_next ? sat(dn_out, qn) : rsi_pkg::MISS_VAL;
            tf_reg  <= hit_next ? sat(df_out, qf) : rsi_pkg::MISS_VAL;
        end
    end

    assign result.valid  = out_v_reg;
    assign result.hit    = hit_reg;
    assign result.t_near = tn_reg;
    assign result.t_far  = tf_reg;

`ifndef SYNTHESIS
    a_miss_val: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.hit |->
            result.t_near == rsi_pkg::MISS_VAL && result.t_far == rsi_pkg::MISS_VAL)
        else $error("miss result without -1.0 roots");

    a_root_order: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.hit |-> result.t_near <= result.t_far)
        else $error("near root above far root");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !ray.ready |-> result.valid && !result.ready)
        else $error("ray request refused without an output stall");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        dn_v == df_v)
        else $error("near and far dividers out of step");
`endif

endmodule

// ----- bench/rsi_checker.sv -----
`timescale 1ns / 1ps
module rsi_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    rsi_ray_if                     ray,
    rsi_hit_if                     result,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_idx,
    input  logic [rsi_pkg::XW-1:0] cfg_data,
    output int                     errors,
    output int                     outstanding,
    output int                     rays_seen,
    output int                     hits_seen
);

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic                          hit;
        logic signed [rsi_pkg::XW-1:0] t_near;
        logic signed [rsi_pkg::XW-1:0] t_far;
    } outcome_t;

    rsi_pkg::cfg_t sphere;
    outcome_t      expected_hits[$];

    function automatic wide_t floor_div(wide_t n, wide_t d);
        wide_t q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic logic signed [rsi_pkg::XW-1:0] clamp_q(wide_t v);
        if (v < wide_t'(rsi_pkg::T_MIN))
            return rsi_pkg::T_MIN;
        if (v > wide_t'(rsi_pkg::T_MAX))
            return rsi_pkg::T_MAX;
        return v[rsi_pkg::XW-1:0];
    endfunction

    function automatic outcome_t solve_intersection(rsi_pkg::ray_t r, rsi_pkg::cfg_t s);
        outcome_t o;
        wide_t a, h, c, d, e, disc, v, root, cand, hs, t1, t2, lo, hi;
        logic signed [rsi_pkg::XW-1:0] org[3], dir[3], cen[3];
        org = '{r.origin_x, r.origin_y, r.origin_z};
        dir = '{r.dir_x, r.dir_y, r.dir_z};
        cen = '{s.center_x, s.center_y, s.center_z};
        a = 0;
        h = 0;
        c = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = wide_t'(dir[i]);
            e = wide_t'(org[i]) - wide_t'(cen[i]);
            a = a + d * d;
            h = h + d * e;
            c = c + e * e;
        end
        v = wide_t'({1'b0, s.sphere_radius});
        c = c - v * v;
        o.hit = 1'b0;
        o.t_near = rsi_pkg::MISS_VAL;
        o.t_far = rsi_pkg::MISS_VAL;
        if (a == 0)
            return o;
        disc = h * h - a * c;
        if (disc < 0)
            return o;
        v = disc <<< (2 * rsi_pkg::FRAC_BITS);
        root = 0;
        for (int i = 95; i >= 0; i--)
        begin
            cand = root | (wide_t'(1) <<< i);
            if (cand * cand <= v)
                root = cand;
        end
        hs = -(h <<< rsi_pkg::FRAC_BITS);
        t1 = floor_div(hs - root, a);
        t2 = floor_div(hs + root, a);
        lo = wide_t'(s.t_lower);
        hi = wide_t'(s.t_upper);
        if (!(t1 >= lo && t1 <= hi) && !(t2 >= lo && t2 <= hi))
            return o;
        o.hit = 1'b1;
        o.t_near = clamp_q(t1);
        o.t_far = clamp_q(t2);
        return o;
    endfunction

    assign outstanding = expected_hits.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sphere.center_x <= '0;
            sphere.center_y <= '0;
            sphere.center_z <= '0;
            sphere.sphere_radius <= 31'd65536;
            sphere.t_lower <= rsi_pkg::ONE_VAL;
            sphere.t_upper <= rsi_pkg::T_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                rsi_pkg::CFG_CENTER_X: sphere.center_x <= cfg_data;
                rsi_pkg::CFG_CENTER_Y: sphere.center_y <= cfg_data;
                rsi_pkg::CFG_CENTER_Z: sphere.center_z <= cfg_data;
                rsi_pkg::CFG_RADIUS:   sphere.sphere_radius <= cfg_data[rsi_pkg::XW-2:0];
                rsi_pkg::CFG_T_LOWER:  sphere.t_lower <= cfg_data;
                rsi_pkg::CFG_T_UPPER:  sphere.t_upper <= cfg_data;
                default: ;
            endcase
        end
    end

    initial
    begin
        errors = 0;
        rays_seen = 0;
        hits_seen = 0;
    end

    always @(posedge clk)
    begin
        rsi_pkg::ray_t r;
        outcome_t      want;
        if (rst_n && ray.valid && ray.ready)
        begin
            r = '{ray.origin_x, ray.origin_y, ray.origin_z, ray.dir_x, ray.dir_y, ray.dir_z};
            expected_hits.push_back(solve_intersection(r, sphere));
            rays_seen++;
        end
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result hit=%0b t_near=%0d t_far=%0d", $time,
                         result.hit, result.t_near, result.t_far);
                errors++;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (result.hit) hits_seen++;
                if (result.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b got %0b", $time, want.hit, result.hit);
                    errors++;
                end
                if (result.t_near !== want.t_near)
                begin
                    $display("%0t: t_near expected %0d got %0d", $time, want.t_near,
                             result.t_near);
                    errors++;
                end
                if (result.t_far !== want.t_far)
                begin
                    $display("%0t: t_far expected %0d got %0d", $time, want.t_far,
                             result.t_far);
                    errors++;
                end
            end
        end
    end
endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;

    localparam int ONE = 65536;
    localparam int STALL_LIMIT = 5000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [2:0]             cfg_idx;
    logic [rsi_pkg::XW-1:0] cfg_data;
    int              errors, outstanding, rays_seen, hits_seen;
    int              tx_idle_pct, rx_idle_pct, hold_req, hold_cnt, quiet;
    int              cx, cy, cz;

    rsi_ray_if ray_ch ();
    rsi_hit_if hit_ch ();

    ray_sphere_intersect DUT (
        .clk(clk), .rst_n(rst_n), .ray(ray_ch), .result(hit_ch),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    rsi_checker checker_i (
        .clk(clk), .rst_n(rst_n), .ray(ray_ch), .result(hit_ch),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .errors(errors), .outstanding(outstanding),
        .rays_seen(rays_seen), .hits_seen(hits_seen)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // result side: random stalls plus one long hold
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            hit_ch.ready <= 1'b0;
        end
        else
            hit_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, int val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        if (idx == rsi_pkg::CFG_CENTER_X) cx = val;
        if (idx == rsi_pkg::CFG_CENTER_Y) cy = val;
        if (idx == rsi_pkg::CFG_CENTER_Z) cz = val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            ray_ch.valid <= 1'b0;
            @(negedge clk);
        end
        ray_ch.valid <= 1'b1;
        ray_ch.origin_x <= ox;
        ray_ch.origin_y <= oy;
        ray_ch.origin_z <= oz;
        ray_ch.dir_x <= dx;
        ray_ch.dir_y <= dy;
        ray_ch.dir_z <= dz;
        do
            @(posedge clk);
        while (!ray_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain();
        ray_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (130) @(negedge clk);
    endtask

    function automatic int around(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic random_ray();
        int kind, ox, oy, oz, sh;
        kind = $urandom_range(99);
        if (kind < 20)
            send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (kind < 60)
        begin
            ox = cx + around(1 << 21);
            oy = cy + around(1 << 21);
            oz = cz + around(1 << 21);
            sh = $urandom_range(0, 4);
            send_ray(ox, oy, oz, (cx + around(1 << 17) - ox) >>> sh,
                     (cy + around(1 << 17) - oy) >>> sh, (cz + around(1 << 17) - oz) >>> sh);
        end
        else
            send_ray(cx + around(1 << 21), cy + around(1 << 21), cz + around(1 << 21),
                     around(1 << 17), around(1 << 17), around(1 << 17));
    endtask

    initial
    begin
        int lo;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        ray_ch.valid = 1'b0;
        ray_ch.origin_x = '0;
        ray_ch.origin_y = '0;
        ray_ch.origin_z = '0;
        ray_ch.dir_x = '0;
        ray_ch.dir_y = '0;
        ray_ch.dir_z = '0;
        hit_ch.ready = 1'b0;
        tx_idle_pct = 30;
        rx_idle_pct = 64;
        hold_req = 0;
        hold_cnt = 0;
        quiet = 0;
        cx = 0;
        cy = 0;
        cz = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // unit sphere at the origin, window from 1.0 upwards
        send_ray(0, 0, -5 * ONE, 0, 0, ONE);
        send_ray(0, ONE, -5 * ONE, 0, 0, ONE);
        send_ray(0, 2 * ONE, -5 * ONE, 0, 0, ONE);
        send_ray(0, 0, -5 * ONE, 0, 0, 0);
        send_ray(0, 0, 0, ONE, 0, 0);
        send_ray(0, 0, 5 * ONE, 0, 0, ONE);
        send_ray(0, 0, 32'h8001_0000, 0, 0, 1);
        send_ray(0, 0, 0, 1, 0, 0);
        send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_ray(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000, 32'h7fff_ffff, 1);
        send_ray(-3 * ONE, 0, 0, ONE / 2, 0, 0);
        send_ray(0, -4 * ONE, 0, 0, 32'h7fff_ffff, 0);
        drain();

        // empty window
        write_reg(rsi_pkg::CFG_T_LOWER, 10 * ONE);
        write_reg(rsi_pkg::CFG_T_UPPER, ONE);
        send_ray(0, 0, -5 * ONE, 0, 0, ONE);
        send_ray(0, 0, 0, ONE, 0, 0);
        drain();
        // single point window on a tangent
        write_reg(rsi_pkg::CFG_T_LOWER, 5 * ONE);
        write_reg(rsi_pkg::CFG_T_UPPER, 5 * ONE);
        send_ray(0, ONE, -5 * ONE, 0, 0, ONE);
        send_ray(0, 0, -5 * ONE, 0, 0, ONE);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            tx_idle_pct = (p < 3) ? 30 : (p < 6) ? 64 : 0;
            rx_idle_pct = (p < 3) ? 64 : (p < 6) ? 30 : 0;
            if (p == 3)
            begin
                write_reg(rsi_pkg::CFG_CENTER_X, 32'h7fff_ffff);
                write_reg(rsi_pkg::CFG_CENTER_Y, 32'h8000_0000);
                write_reg(rsi_pkg::CFG_CENTER_Z, 0);
                write_reg(rsi_pkg::CFG_RADIUS, 32'h7fff_ffff);
                write_reg(rsi_pkg::CFG_T_LOWER, 32'h8000_0000);
                write_reg(rsi_pkg::CFG_T_UPPER, 32'h7fff_ffff);
            end
            else if (p == 5)
            begin
                write_reg(rsi_pkg::CFG_CENTER_X, around(1 << 20));
                write_reg(rsi_pkg::CFG_CENTER_Y, around(1 << 20));
                write_reg(rsi_pkg::CFG_CENTER_Z, around(1 << 20));
                write_reg(rsi_pkg::CFG_RADIUS, 0);
                write_reg(rsi_pkg::CFG_T_LOWER, 32'h8000_0000);
                write_reg(rsi_pkg::CFG_T_UPPER, 32'h7fff_ffff);
            end
            else
            begin
                write_reg(rsi_pkg::CFG_CENTER_X, around(1 << 20));
                write_reg(rsi_pkg::CFG_CENTER_Y, around(1 << 20));
                write_reg(rsi_pkg::CFG_CENTER_Z, around(1 << 20));
                write_reg(rsi_pkg::CFG_RADIUS, $urandom_range(1 << 14, 1 << 20));
                lo = around(1 << 18);
                write_reg(rsi_pkg::CFG_T_LOWER, lo);
                write_reg(rsi_pkg::CFG_T_UPPER,
                          (p % 2) ? 32'h7fff_ffff : lo + $urandom_range(1 << 20));
            end
            if (p == 1)
                hold_req = 400;
            for (int i = 0; i < 142; i++)
                random_ray();
            drain();
        end

        $display("rays sent %0d, results checked with %0d hits, over eight register settings",
                 rays_seen, hits_seen);
        $display("covered stalls on both sides, a long result hold, extremes and empty windows");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
